// ===== src/r16c_pkg.sv =====
// Shared types, codes and constants for the 16-bit instruction execute core.
// No dependencies; used by r16c_exec and risc16_instruction_core.
package r16c_pkg;

   localparam int unsigned XLEN      = 32;
   localparam int unsigned REG_COUNT = 8;
   localparam int unsigned REG_AW    = $clog2(REG_COUNT);

   // Register that receives the return address of a linked register branch.
   localparam logic [REG_AW-1:0] LINK_REG = REG_AW'(7);

   // Kind of word on the request channel.
   localparam logic ACT_FETCH     = 1'b0;
   localparam logic ACT_LOAD_DATA = 1'b1;

   // Data access request codes on the result channel.
   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_READ  = 2'd1;
   localparam logic [1:0] MEM_WRITE = 2'd2;

   // Major opcodes, instruction bits 15..12.
   localparam logic [3:0] OP_ALU0  = 4'h0;
   localparam logic [3:0] OP_ALU1  = 4'h1;
   localparam logic [3:0] OP_LOAD  = 4'h4;
   localparam logic [3:0] OP_LDPC  = 4'h5;
   localparam logic [3:0] OP_STORE = 4'h6;
   localparam logic [3:0] OP_LDI   = 4'h7;
   localparam logic [3:0] OP_BZ    = 4'h8;
   localparam logic [3:0] OP_BNZ   = 4'h9;
   localparam logic [3:0] OP_BRA   = 4'ha;
   localparam logic [3:0] OP_BREG  = 4'hb;

   typedef enum logic [2:0] {
      ALU_ADD = 3'd0,
      ALU_SUB = 3'd1,
      ALU_AND = 3'd2,
      ALU_OR  = 3'd3,
      ALU_XOR = 3'd4,
      ALU_LSL = 3'd5,
      ALU_LSR = 3'd6,
      ALU_ASR = 3'd7
   } alu_op_type;

   typedef struct packed {
      logic              load_waiting;
      logic [REG_AW-1:0] load_dest;
      logic              load_discard;
      logic              stopped;
   } core_state_type;

   typedef struct packed {
      logic              en;
      logic [REG_AW-1:0] addr;
      logic [XLEN-1:0]   data;
   } reg_write_type;

   typedef struct packed {
      logic [1:0]      mem_op;
      logic [XLEN-1:0] mem_addr;
      logic [XLEN-1:0] write_data;
      logic [XLEN-1:0] fetch_addr;
      logic            halted;
   } result_type;

endpackage

// ===== src/r16c_exec.sv =====
// Combinational decode and execute logic for one request word.
// Depends on r16c_pkg for codes and the state, write and result structs.
module r16c_exec (
   input  logic                              action,
   input  logic [r16c_pkg::XLEN-1:0]         data,
   input  logic [r16c_pkg::XLEN-1:0]         pc,
   input  r16c_pkg::core_state_type          state,
   input  logic [r16c_pkg::XLEN-1:0]         rd_a,
   input  logic [r16c_pkg::XLEN-1:0]         rd_b,
   output r16c_pkg::core_state_type          state_next,
   output logic [r16c_pkg::XLEN-1:0]         pc_next,
   output r16c_pkg::reg_write_type           reg_wr,
   output r16c_pkg::result_type              result
);
   import r16c_pkg::*;

   logic [15:0]       ins;
   logic [3:0]        op;
   logic [REG_AW-1:0] fld_d;
   logic [REG_AW-1:0] fld_a;
   logic [XLEN-1:0]   pc_inc;
   logic [XLEN-1:0]   alu_b;
   logic [XLEN-1:0]   alu_out;
   logic [4:0]        shamt;
   logic              shift_big;
   logic [XLEN-1:0]   ls_addr;
   alu_op_type        alu_op;

   assign ins    = pc[1] ? data[15:0] : data[31:16];
   assign op     = ins[15:12];
   assign fld_d  = ins[2:0];
   assign fld_a  = ins[5:3];
   assign pc_inc = pc + XLEN'(2);
   assign alu_op = alu_op_type'(ins[12:10]);

   // Second operand is a register when bit 9 is set, else a 3-bit immediate.
   assign alu_b     = ins[9] ? rd_b : {{(XLEN-3){1'b0}}, ins[8:6]};
   assign shamt     = alu_b[4:0];
   assign shift_big = |alu_b[XLEN-1:5];
   assign ls_addr   = rd_a + {{(XLEN-7){ins[11]}}, ins[11:7], 2'b00};

   always_comb begin
      case (alu_op)
         ALU_ADD: alu_out = rd_a + alu_b;
         ALU_SUB: alu_out = rd_a - alu_b;
         ALU_AND: alu_out = rd_a & alu_b;
         ALU_OR:  alu_out = rd_a | alu_b;
         ALU_XOR: alu_out = rd_a ^ alu_b;
         ALU_LSL: alu_out = shift_big ? '0 : (rd_a << shamt);
         ALU_LSR: alu_out = shift_big ? '0 : (rd_a >> shamt);
         ALU_ASR: alu_out = shift_big ? {XLEN{rd_a[XLEN-1]}}
                                      : XLEN'($signed(rd_a) >>> shamt);
         default: alu_out = '0;
      endcase
   end

   always_comb begin
      state_next = state;
      pc_next    = pc;
      reg_wr     = '0;
      result     = '0;

      if (!state.stopped && action == ACT_LOAD_DATA) begin
         if (state.load_waiting) begin
            reg_wr.en               = !state.load_discard;
            reg_wr.addr             = state.load_dest;
            reg_wr.data             = data;
            state_next.load_waiting = 1'b0;
            state_next.load_discard = 1'b0;
         end
      end else if (!state.stopped && !state.load_waiting) begin
         pc_next = pc_inc;
         case (op) inside
            OP_ALU0, OP_ALU1: begin
               reg_wr.en   = 1'b1;
               reg_wr.addr = fld_d;
               reg_wr.data = alu_out;
            end
            OP_LOAD, OP_STORE: begin
               result.mem_addr = ls_addr;
               if (op == OP_LOAD) begin
                  result.mem_op           = MEM_READ;
                  state_next.load_waiting = 1'b1;
                  state_next.load_dest    = fld_d;
                  state_next.load_discard = ins[6] && (fld_a == fld_d);
               end else begin
                  result.mem_op     = MEM_WRITE;
                  result.write_data = rd_b;
               end
               // Base writeback of the computed address.
               reg_wr.en   = ins[6];
               reg_wr.addr = fld_a;
               reg_wr.data = ls_addr;
            end
            OP_LDPC: begin
               result.mem_op   = MEM_READ;
               result.mem_addr = {pc_inc[XLEN-1:2], 2'b00}
                               + {{(XLEN-11){ins[11]}}, ins[11:3], 2'b00};
               state_next.load_waiting = 1'b1;
               state_next.load_dest    = fld_d;
               state_next.load_discard = 1'b0;
            end
            OP_LDI: begin
               reg_wr.en   = 1'b1;
               reg_wr.addr = fld_d;
               reg_wr.data = {{(XLEN-9){ins[11]}}, ins[11:3]};
            end
            OP_BZ, OP_BNZ: begin
               if ((op == OP_BZ) == (rd_b == '0)) begin
                  pc_next = pc_inc + {{(XLEN-10){ins[11]}}, ins[11:3], 1'b0};
               end
            end
            OP_BRA: begin
               pc_next = pc_inc + {{(XLEN-13){ins[11]}}, ins[11:0], 1'b0};
            end
            OP_BREG: begin
               reg_wr.en   = ins[11];
               reg_wr.addr = LINK_REG;
               reg_wr.data = pc_inc;
               pc_next     = rd_b;
            end
            default: begin
               state_next.stopped = 1'b1;
            end
         endcase
      end

      result.fetch_addr = pc_next;
      result.halted     = state_next.stopped;
   end

endmodule

// ===== src/risc16_instruction_core.sv =====
// Execute core for a 16-bit instruction set with eight 32-bit registers.
// An accepted word waits in the input stage; its result word is registered when it fires.
// Throughput: one request word per cycle; the register file read and the execute
// stage do not hold words back, so the core only stalls when the result is held.
// Reset: synchronous; registers read as zero until written (per-register valid
// bits), pc, load tracking and halted state return to zero. No clearing pass.
module risc16_instruction_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_action,
   input  logic [r16c_pkg::XLEN-1:0]     req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_mem_op,
   output logic [r16c_pkg::XLEN-1:0]     rsp_mem_addr,
   output logic [r16c_pkg::XLEN-1:0]     rsp_write_data,
   output logic [r16c_pkg::XLEN-1:0]     rsp_fetch_addr,
   output logic                          rsp_halted
);
   import r16c_pkg::*;

   // Input stage: the accepted word plus the two register reads it needs.
   logic                in_v_ff, in_v_in;
   logic                in_action_ff;
   logic [XLEN-1:0]     in_data_ff;
   logic [XLEN-1:0]     rd_a_ff, rd_b_ff;

   // Architectural state. The register file is a small memory with two
   // registered read ports and one write port.
   logic [XLEN-1:0]      regs_mem [REG_COUNT];
   logic [REG_COUNT-1:0] reg_vld_ff, reg_vld_in;
   logic [XLEN-1:0]      pc_ff, pc_in;
   core_state_type       state_ff, state_in;

   // Result register.
   logic       out_v_ff, out_v_in;
   result_type out_ff;

   core_state_type  exec_state;
   logic [XLEN-1:0] exec_pc;
   reg_write_type   exec_wr;
   result_type      exec_res;
   reg_write_type   wr;

   logic              accept;
   logic              fire;
   logic [XLEN-1:0]   acc_pc;
   logic [15:0]       acc_ins;
   logic [3:0]        acc_op;
   logic [REG_AW-1:0] raddr_a, raddr_b;

   // The execute stage fires whenever it holds a word and the result register
   // is free or being emptied this cycle. A new word enters only when the
   // input stage is empty or its word moves on at the same edge.
   assign fire      = in_v_ff && (!out_v_ff || !rsp_stall);
   assign req_stall = in_v_ff && !fire;
   assign accept    = req_valid && !req_stall;

   r16c_exec u_exec (
      .action     (in_action_ff),
      .data       (in_data_ff),
      .pc         (pc_ff),
      .state      (state_ff),
      .rd_a       (rd_a_ff),
      .rd_b       (rd_b_ff),
      .state_next (exec_state),
      .pc_next    (exec_pc),
      .reg_wr     (exec_wr),
      .result     (exec_res)
   );

   // Nothing architectural changes unless the execute stage fires.
   always_comb begin
      wr    = exec_wr;
      wr.en = exec_wr.en && fire;
   end

   // Register read addresses for the incoming word are decoded from the
   // halfword that the pc selects once the word ahead of it has finished.
   // Port A always reads the base field; port B reads the register operand of
   // an ALU instruction and the d field of everything else.
   assign acc_pc  = fire ? exec_pc : pc_ff;
   assign acc_ins = acc_pc[1] ? req_data[15:0] : req_data[31:16];
   assign acc_op  = acc_ins[15:12];
   assign raddr_a = acc_ins[5:3];
   assign raddr_b = (acc_op == OP_ALU0 || acc_op == OP_ALU1) ? acc_ins[8:6]
                                                             : acc_ins[2:0];

   always_comb begin
      reg_vld_in = reg_vld_ff;
      if (wr.en) begin
         reg_vld_in[wr.addr] = 1'b1;
      end
   end

   // Register file write, and reads that see a write made at the same edge.
   // An entry never written reads as zero.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         regs_mem[wr.addr] <= wr.data;
      end
      if (accept) begin
         if (wr.en && wr.addr == raddr_a) begin
            rd_a_ff <= wr.data;
         end else begin
            rd_a_ff <= reg_vld_ff[raddr_a] ? regs_mem[raddr_a] : '0;
         end
         if (wr.en && wr.addr == raddr_b) begin
            rd_b_ff <= wr.data;
         end else begin
            rd_b_ff <= reg_vld_ff[raddr_b] ? regs_mem[raddr_b] : '0;
         end
      end
   end

   assign in_v_in  = accept ? 1'b1 : (fire ? 1'b0 : in_v_ff);
   assign out_v_in = fire ? 1'b1 : (rsp_stall ? out_v_ff : 1'b0);
   assign pc_in    = fire ? exec_pc : pc_ff;
   assign state_in = fire ? exec_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff    <= 1'b0;
         out_v_ff   <= 1'b0;
         reg_vld_ff <= '0;
         pc_ff      <= '0;
         state_ff   <= '0;
      end else begin
         in_v_ff    <= in_v_in;
         out_v_ff   <= out_v_in;
         reg_vld_ff <= reg_vld_in;
         pc_ff      <= pc_in;
         state_ff   <= state_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_action_ff <= req_action;
         in_data_ff   <= req_data;
      end
      if (fire) begin
         out_ff <= exec_res;
      end
   end

   assign rsp_valid      = out_v_ff;
   assign rsp_mem_op     = out_ff.mem_op;
   assign rsp_mem_addr   = out_ff.mem_addr;
   assign rsp_write_data = out_ff.write_data;
   assign rsp_fetch_addr = out_ff.fetch_addr;
   assign rsp_halted     = out_ff.halted;

   // While a load is outstanding, no word may start another data access.
   a_no_access_while_waiting: assert property (@(posedge clock) disable iff (reset)
      fire && state_ff.load_waiting |=> rsp_mem_op == MEM_NONE)
      else $error("data access issued while a load was outstanding");

   // Once halted, the core stays halted until reset.
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff.stopped |=> state_ff.stopped)
      else $error("halted state cleared without reset");

   // A read request always leaves a load pending for the returning data.
   a_read_sets_waiting: assert property (@(posedge clock) disable iff (reset)
      fire && exec_res.mem_op == MEM_READ |=> state_ff.load_waiting)
      else $error("read request issued without tracking the pending load");

   // A halted core neither advances its pc nor writes registers.
   a_halt_quiet: assert property (@(posedge clock) disable iff (reset)
      fire && state_ff.stopped |-> !wr.en && exec_pc == pc_ff)
      else $error("halted core changed architectural state");

endmodule
